// ===== rtl/knn_pkg.sv =====
`default_nettype none
package knn_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned MaxK       = 8;
  localparam int unsigned NumDims    = 4;
  localparam int unsigned NumClasses = 16;

  localparam int unsigned CoordW = 16;
  localparam int unsigned LabelW = 4;
  localparam int unsigned KW     = 4;
  localparam int unsigned DistW  = 35;

  localparam logic [KW-1:0] KReset = 4'd3;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic [3:0]        label;
  } in_word_t;

  typedef struct packed {
    logic [3:0] class_id;
    logic [3:0] vote_count;
    logic       store_empty;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VOTE,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/knn_ram.sv =====
`default_nettype none
module knn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/knn_dist.sv =====
`default_nettype none
// two-stage squared distance: per-axis squares, then sum
module knn_dist #(
  parameter int unsigned NumDims = knn_pkg::NumDims
) (
  input  wire logic                        clk_i,
  input  wire logic [4*knn_pkg::CoordW-1:0] query_i,
  input  wire logic [4*knn_pkg::CoordW-1:0] point_i,
  output logic      [knn_pkg::DistW-1:0]    dist_o
);
  logic [32:0] sq_q [4];

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 4; d++) begin
      logic signed [16:0] diff;
      logic [16:0] mag;
      diff = 17'($signed(query_i[d*16 +: 16])) - 17'($signed(point_i[d*16 +: 16]));
      mag  = diff[16] ? 17'(-diff) : diff;
      sq_q[d] <= (d < int'(NumDims)) ? 33'({16'd0, mag} * {16'd0, mag}) : 33'd0;
    end
    dist_o <= 35'(sq_q[0]) + 35'(sq_q[1]) + 35'(sq_q[2]) + 35'(sq_q[3]);
  end
endmodule
`default_nettype wire

// ===== rtl/knn_vote.sv =====
`default_nettype none
// serial vote: one neighbour a cycle tallied, then one label a cycle compared
module knn_vote #(
  parameter int unsigned MaxK       = knn_pkg::MaxK,
  parameter int unsigned NumClasses = knn_pkg::NumClasses
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [$clog2(MaxK+1)-1:0]      used_i,
  input  wire logic [MaxK-1:0][knn_pkg::LabelW-1:0] labels_i,
  output logic                                done_o,
  output logic [knn_pkg::LabelW-1:0]          best_o,
  output logic [knn_pkg::KW-1:0]              count_o
);
  localparam int unsigned CW  = $clog2(MaxK+1);
  localparam int unsigned IW  = (MaxK + NumClasses > 2) ? $clog2(MaxK + NumClasses) : 1;
  localparam int unsigned KIW = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int unsigned CIW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int unsigned LW  = knn_pkg::LabelW;

  logic [NumClasses-1:0][CW-1:0] tally_q;
  logic [IW-1:0] idx_q;
  logic busy_q;
  logic [CW-1:0] bestc_q;
  logic [LW-1:0] best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        idx_q   <= '0;
        tally_q <= '0;
        bestc_q <= '0;
        best_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        if (32'(idx_q) < MaxK) begin
          if (32'(idx_q) < 32'(used_i)) begin
            tally_q[CIW'(labels_i[idx_q[KIW-1:0]])] <=
              tally_q[CIW'(labels_i[idx_q[KIW-1:0]])] + 1'b1;
          end
        end else begin
          if (tally_q[CIW'(32'(idx_q) - MaxK)] > bestc_q) begin
            bestc_q <= tally_q[CIW'(32'(idx_q) - MaxK)];
            best_q  <= LW'(32'(idx_q) - MaxK);
          end
          if (32'(idx_q) == MaxK + NumClasses - 1) begin
            busy_q <= 1'b0;
            done_o <= 1'b1;
          end
        end
      end
    end
  end

  assign best_o  = best_q;
  assign count_o = knn_pkg::KW'(bestc_q);
endmodule
`default_nettype wire

// ===== rtl/knn_classifier.sv =====
`default_nettype none
// a query reads the training memory one point a cycle, limited by its single read port
// one word handled at a time; the result sits in an output register while idle
// reset (async, active low) empties the store and sets k to 3; memory contents are
// left as they are, only entries below the point count are ever read
module knn_classifier #(
  parameter int unsigned StoreDepth = knn_pkg::StoreDepth,
  parameter int unsigned MaxK       = knn_pkg::MaxK,
  parameter int unsigned NumDims    = knn_pkg::NumDims,
  parameter int unsigned NumClasses = knn_pkg::NumClasses
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire knn_pkg::in_word_t    in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output knn_pkg::out_word_t        out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [3:0]           cfg_data_i
);
  localparam int unsigned AW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned NW  = $clog2(StoreDepth + 1);
  localparam int unsigned UW  = $clog2(MaxK + 1);
  localparam int unsigned KIW = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int unsigned DW  = knn_pkg::DistW;
  localparam int unsigned LW  = knn_pkg::LabelW;

  knn_pkg::state_e state_q, state_d;
  logic [NW-1:0] count_q;
  logic [3:0]    k_q;
  logic [NW-1:0] rd_q;    // next slot to read
  logic [NW-1:0] got_q;   // distances consumed
  knn_pkg::in_word_t cur_q;
  logic [MaxK-1:0][DW-1:0] nd_q;
  logic [MaxK-1:0][LW-1:0] nl_q;
  logic [UW-1:0] used_q;
  logic [UW-1:0] keff;
  logic [2:0] vld_pipe_q;  // read valid travelling beside the distance pipe
  logic [LW-1:0] lab_p1_q, lab_p2_q;
  knn_pkg::out_word_t out_q;
  logic out_v_q;

  logic [63:0] coords_rd, dist_pt;
  logic [LW-1:0] lab_rd;
  logic [DW-1:0] dist_sq;
  logic vote_start, vote_done;
  logic [LW-1:0] vote_best;
  logic [3:0] vote_cnt;
  logic acc;
  logic load_we;

  assign acc = in_valid_i && in_ready_o;
  assign load_we = acc && in_data_i.cmd == knn_pkg::CMD_LOAD && 32'(count_q) < StoreDepth;

  // effective k, clipped to 1..MaxK
  always_comb begin
    if (k_q == 4'd0) keff = UW'(1);
    else if (32'(k_q) > MaxK) keff = UW'(MaxK);
    else keff = UW'(k_q);
  end

  knn_ram #(.Width(64), .Depth(StoreDepth)) u_coords (
    .clk_i, .we_i(load_we), .waddr_i(AW'(count_q)),
    .wdata_i({in_data_i.coord_3, in_data_i.coord_2, in_data_i.coord_1, in_data_i.coord_0}),
    .raddr_i(AW'(rd_q)), .rdata_o(coords_rd)
  );
  knn_ram #(.Width(LW), .Depth(StoreDepth)) u_labels (
    .clk_i, .we_i(load_we), .waddr_i(AW'(count_q)),
    .wdata_i(LW'(32'(in_data_i.label) % NumClasses)),
    .raddr_i(AW'(rd_q)), .rdata_o(lab_rd)
  );
  assign dist_pt = coords_rd;

  knn_dist #(.NumDims(NumDims)) u_dist (
    .clk_i,
    .query_i({cur_q.coord_3, cur_q.coord_2, cur_q.coord_1, cur_q.coord_0}),
    .point_i(dist_pt), .dist_o(dist_sq)
  );

  knn_vote #(.MaxK(MaxK), .NumClasses(NumClasses)) u_vote (
    .clk_i, .rst_ni, .start_i(vote_start), .used_i(used_q), .labels_i(nl_q),
    .done_o(vote_done), .best_o(vote_best), .count_o(vote_cnt)
  );

  // farthest kept neighbour, lowest slot on ties
  logic [KIW-1:0] far;
  always_comb begin
    far = '0;
    for (int j = 1; j < int'(MaxK); j++) begin
      if (j < int'(used_q) && nd_q[j] > nd_q[far]) far = KIW'(j);
    end
  end

  logic dist_v;
  assign dist_v = vld_pipe_q[2];

  always_comb begin
    state_d = state_q;
    vote_start = 1'b0;
    in_ready_o = (state_q == knn_pkg::ST_IDLE) && !out_v_q;
    unique case (state_q)
      knn_pkg::ST_IDLE: begin
        if (acc && in_data_i.cmd == knn_pkg::CMD_CLASSIFY && count_q != '0) begin
          state_d = knn_pkg::ST_SCAN;
        end
      end
      knn_pkg::ST_SCAN:  if (rd_q == count_q) state_d = knn_pkg::ST_DRAIN;
      knn_pkg::ST_DRAIN: if (got_q == count_q) begin
        state_d = knn_pkg::ST_VOTE;
        vote_start = 1'b1;
      end
      knn_pkg::ST_VOTE:  if (vote_done) state_d = knn_pkg::ST_IDLE;
      default:           state_d = knn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= knn_pkg::ST_IDLE;
      count_q    <= '0;
      k_q        <= knn_pkg::KReset;
      rd_q       <= '0;
      got_q      <= '0;
      used_q     <= '0;
      vld_pipe_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) k_q <= cfg_data_i;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      // read valid: ram (1) then distance (2)
      vld_pipe_q <= {vld_pipe_q[1:0], state_q == knn_pkg::ST_SCAN && rd_q != count_q};
      if (state_q == knn_pkg::ST_SCAN && rd_q != count_q) rd_q <= rd_q + 1'b1;
      if (acc) begin
        unique case (in_data_i.cmd)
          knn_pkg::CMD_LOAD:  if (load_we) count_q <= count_q + 1'b1;
          knn_pkg::CMD_CLEAR: count_q <= '0;
          knn_pkg::CMD_CLASSIFY: begin
            rd_q <= '0;
            got_q <= '0;
            used_q <= '0;
            if (count_q == '0) out_v_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (dist_v) begin
        got_q <= got_q + 1'b1;
        if (used_q < keff) used_q <= used_q + 1'b1;
      end
      if (vote_done) out_v_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lab_p1_q <= lab_rd;
    lab_p2_q <= lab_p1_q;
    if (acc) cur_q <= in_data_i;
    if (acc && in_data_i.cmd == knn_pkg::CMD_CLASSIFY && count_q == '0) begin
      out_q <= '{class_id: '0, vote_count: '0, store_empty: 1'b1};
    end
    if (vote_done) out_q <= '{class_id: vote_best, vote_count: vote_cnt, store_empty: 1'b0};
    if (dist_v) begin
      if (used_q < keff) begin
        nd_q[used_q[KIW-1:0]] <= dist_sq;
        nl_q[used_q[KIW-1:0]] <= lab_p2_q;
      end else if (dist_sq < nd_q[far]) begin
        nd_q[far] <= dist_sq;
        nl_q[far] <= lab_p2_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ===== rtl/knn_checker.sv =====
`default_nettype none
module knn_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire knn_pkg::out_word_t out_data_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.store_empty |-> out_data_o.class_id == 4'd0 &&
      out_data_o.vote_count == 4'd0)
    else $error("empty result not zero");
  a_votes_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.store_empty |-> out_data_o.vote_count != 4'd0 &&
      out_data_o.vote_count <= 4'd8)
    else $error("vote count out of range");
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");
endmodule

bind knn_classifier knn_checker u_knn_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_data_o, .out_valid_o, .out_ready_i
);
`default_nettype wire
